>>> rtl/core/rau_pkg.sv
`default_nettype none
package rau_pkg;

  localparam int unsigned FW = 32;           // field width
  localparam int unsigned MW = 64;           // wide magnitude width

  typedef enum logic [1:0] {
    KIND_ADD = 2'd0,
    KIND_SUB = 2'd1,
    KIND_MUL = 2'd2,
    KIND_DIV = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_ZERO_DEN = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic signed [31:0] first_num;
    logic signed [31:0] first_den;
    logic signed [31:0] second_num;
    logic signed [31:0] second_den;
  } in_beat_t;

  typedef struct packed {
    logic signed [31:0] result_num;
    logic [30:0]        result_den;
    logic [1:0]         status;
  } out_beat_t;

  // datapath commands
  typedef struct packed {
    logic load;      // capture operands, check zero denominators
    logic mul;       // one product step (selected by mul_sel)
    logic [1:0] mul_sel;
    logic combine;   // form num/den from products
    logic div_start; // start a divide of div_a by div_b
    logic [1:0] div_mode; // what the divider works on
    logic gcd_step;  // x <= y, y <= remainder
    logic red_num;   // num <= quotient
    logic red_den;   // den <= quotient
    logic finish;    // form output beat
  } dp_cmd_t;

  typedef struct packed {
    logic bad_den;    // zero denominator or divide by zero
    logic num_zero;
    logic y_zero;
    logic div_done;
  } dp_stat_t;

  localparam logic [1:0] DM_GCD = 2'd0;
  localparam logic [1:0] DM_NUM = 2'd1;
  localparam logic [1:0] DM_DEN = 2'd2;

endpackage
`default_nettype wire

>>> rtl/core/rau_divider.sv
`default_nettype none
// restoring divider, one quotient bit per cycle
module rau_divider (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   start,
  input  wire logic [rau_pkg::MW-1:0] dividend,
  input  wire logic [rau_pkg::MW-1:0] divisor,
  output logic                        done,
  output logic [rau_pkg::MW-1:0]      quotient,
  output logic [rau_pkg::MW-1:0]      remainder
);
  localparam int unsigned MW = rau_pkg::MW;

  logic [MW-1:0] q_r, q_nxt, rem_r, rem_nxt, dvs_r, dvs_nxt;
  logic [6:0]    cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt, done_r, done_nxt;
  logic [MW:0]   trial;
  logic [MW:0]   shifted;

  always_comb begin
    shifted  = {rem_r, q_r[MW-1]};
    trial    = shifted - {1'b0, dvs_r};
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      q_nxt    = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
      cnt_nxt  = 7'(MW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[MW]) begin
        rem_nxt = trial[MW-1:0];
        q_nxt   = {q_r[MW-2:0], 1'b1};
      end else begin
        rem_nxt = shifted[MW-1:0];
        q_nxt   = {q_r[MW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 7'd1;
      if (cnt_r == 7'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign done      = done_r;
  assign quotient  = q_r;
  assign remainder = rem_r;

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r) else $error("divider done while busy");
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> busy_r) else $error("divider did not start");
endmodule
`default_nettype wire

>>> rtl/core/rau_datapath.sv
`default_nettype none
module rau_datapath #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire rau_pkg::in_beat_t  in_beat,
  input  wire rau_pkg::dp_cmd_t   cmd,
  output rau_pkg::dp_stat_t       stat,
  output rau_pkg::out_beat_t      out_beat
);
  localparam int unsigned MW = rau_pkg::MW;
  localparam logic [MW-1:0] LIMIT = MW'(1) << (VALUE_WIDTH - 1);

  logic [1:0]  kind_r;
  logic [32:0] m_r [4];   // magnitudes n1 d1 n2 d2
  logic        s_r [4];
  logic        bad_r;
  logic [MW-1:0] p_r [3]; logic ps_r [3];   // products
  logic [MW-1:0] num_r, den_r, x_r, y_r;
  logic          nneg_r;
  logic [MW:0]   sum;
  logic [32:0]   ma, mb;
  logic          sa, sb;
  logic [MW-1:0] div_a, div_b, quo, rem;
  logic          div_done;
  rau_pkg::out_beat_t ob_r;

  function automatic logic [32:0] mag(input logic [31:0] v);
    mag = v[31] ? (33'h1_0000_0000 - {1'b0, v}) : {1'b0, v};
  endfunction

  always_comb begin
    unique case (cmd.mul_sel)
      2'd0:    begin ma = m_r[0]; sa = s_r[0]; mb = m_r[3]; sb = s_r[3]; end // n1*d2
      2'd1:    begin ma = m_r[2]; sa = s_r[2]; mb = m_r[1]; sb = s_r[1]; end // n2*d1
      2'd2:    begin ma = m_r[1]; sa = s_r[1]; mb = m_r[3]; sb = s_r[3]; end // d1*d2
      default: begin ma = m_r[0]; sa = s_r[0]; mb = m_r[2]; sb = s_r[2]; end // n1*n2
    endcase
  end

  always_comb begin
    unique case (cmd.div_mode)
      rau_pkg::DM_NUM: begin div_a = num_r; div_b = x_r; end
      rau_pkg::DM_DEN: begin div_a = den_r; div_b = x_r; end
      default:         begin div_a = x_r;   div_b = y_r; end
    endcase
  end

  rau_divider u_div (
    .clk(clk), .rst_n(rst_n), .start(cmd.div_start), .dividend(div_a),
    .divisor(div_b), .done(div_done), .quotient(quo), .remainder(rem)
  );

  logic [65:0]   prod_w;
  logic [MW-1:0] prod;
  logic          psign;
  logic [MW-1:0] amag, bmag;
  logic          aneg, bneg;
  logic          cneg;
  logic [MW-1:0] cmag;
  // 33 x 33 magnitudes, at most 2^62
  assign prod_w = ma * mb;
  assign prod   = prod_w[MW-1:0];
  assign psign  = (sa != sb) && (prod != '0);

  always_comb begin
    // p_r[0]=first cross or n1*n2, p_r[1]=second cross n2*d1, p_r[2]=d1*d2 (den unless divide)
    amag = p_r[0]; aneg = ps_r[0];
    bmag = p_r[1]; bneg = ps_r[1] ^ ((kind_r == rau_pkg::KIND_SUB) && (p_r[1] != '0));
    sum  = '0;
    if (aneg == bneg) begin
      sum = {1'b0, amag} + {1'b0, bmag}; cneg = aneg;
    end else if (amag >= bmag) begin
      sum = {1'b0, amag - bmag}; cneg = aneg;
    end else begin
      sum = {1'b0, bmag - amag}; cneg = bneg;
    end
    cmag = sum[MW-1:0];
    if (kind_r == rau_pkg::KIND_MUL || kind_r == rau_pkg::KIND_DIV) begin
      cmag = p_r[0]; cneg = ps_r[0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r <= in_beat.kind;
      m_r[0] <= mag(in_beat.first_num);  s_r[0] <= in_beat.first_num[31];
      m_r[1] <= mag(in_beat.first_den);  s_r[1] <= in_beat.first_den[31];
      m_r[2] <= mag(in_beat.second_num); s_r[2] <= in_beat.second_num[31];
      m_r[3] <= mag(in_beat.second_den); s_r[3] <= in_beat.second_den[31];
      bad_r  <= (in_beat.first_den == '0) || (in_beat.second_den == '0) ||
                ((in_beat.kind == rau_pkg::KIND_DIV) && (in_beat.second_num == '0));
    end
    if (cmd.mul) begin
      // slot: sel0->0, sel3->0, sel1->1, sel2->2
      unique case (cmd.mul_sel)
        2'd1:    begin p_r[1] <= prod; ps_r[1] <= psign; end
        2'd2:    begin p_r[2] <= prod; ps_r[2] <= psign; end
        default: begin p_r[0] <= prod; ps_r[0] <= psign; end
      endcase
    end
    if (cmd.combine) begin
      num_r  <= cmag;
      // divide: den = d1*n2 sits in slot 1
      if (kind_r == rau_pkg::KIND_DIV) begin
        den_r  <= p_r[1];
        nneg_r <= (cmag != '0) && (cneg ^ ps_r[1]);
        y_r    <= p_r[1];
      end else begin
        den_r  <= p_r[2];
        nneg_r <= (cmag != '0) && (cneg ^ ps_r[2]);
        y_r    <= p_r[2];
      end
      x_r <= cmag;
    end
    if (cmd.gcd_step) begin
      x_r <= y_r;
      y_r <= rem;
    end
    if (cmd.red_num) num_r <= quo;
    if (cmd.red_den) den_r <= quo;
    if (cmd.finish) begin
      if (bad_r) begin
        ob_r.result_num <= '0; ob_r.result_den <= 31'd1; ob_r.status <= rau_pkg::ST_ZERO_DEN;
      end else if (num_r == '0) begin
        ob_r.result_num <= '0; ob_r.result_den <= 31'd1; ob_r.status <= rau_pkg::ST_OK;
      end else if ((den_r > LIMIT - MW'(1)) ||
                   (nneg_r ? (num_r > LIMIT) : (num_r > LIMIT - MW'(1)))) begin
        ob_r.result_num <= '0; ob_r.result_den <= 31'd1; ob_r.status <= rau_pkg::ST_OVERFLOW;
      end else begin
        ob_r.result_num <= nneg_r ? (32'd0 - num_r[31:0]) : num_r[31:0];
        ob_r.result_den <= den_r[30:0];
        ob_r.status     <= rau_pkg::ST_OK;
      end
    end
  end

  assign stat.bad_den  = bad_r;
  assign stat.num_zero = (num_r == '0);
  assign stat.y_zero   = (y_r == '0);
  assign stat.div_done = div_done;
  assign out_beat      = ob_r;
endmodule
`default_nettype wire

>>> rtl/core/rau_ctrl.sv
`default_nettype none
module rau_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  output logic                  out_valid,
  input  wire logic             out_stall,
  input  wire logic [1:0]       kind,
  input  wire rau_pkg::dp_stat_t stat,
  output rau_pkg::dp_cmd_t      cmd
);
  typedef enum logic [9:0] {
    S_IDLE  = 10'b00_0000_0001,
    S_MUL0  = 10'b00_0000_0010,
    S_MUL1  = 10'b00_0000_0100,
    S_MUL2  = 10'b00_0000_1000,
    S_COMB  = 10'b00_0001_0000,
    S_GCD   = 10'b00_0010_0000,
    S_GWAIT = 10'b00_0100_0000,
    S_RNUM  = 10'b00_1000_0000,
    S_RDEN  = 10'b01_0000_0000,
    S_OUT   = 10'b10_0000_0000
  } state_t;

  state_t state_r, state_nxt;
  logic [1:0] kind_r, kind_nxt;
  logic out_valid_r, out_valid_nxt;
  logic waiting_r, waiting_nxt;

  always_comb begin
    state_nxt     = state_r;
    kind_nxt      = kind_r;
    out_valid_nxt = out_valid_r && out_stall;
    waiting_nxt   = waiting_r;
    cmd           = '0;
    in_stall      = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load  = 1'b1;
          kind_nxt  = kind;
          state_nxt = S_MUL0;
        end
      end
      S_MUL0: begin
        cmd.mul     = 1'b1;
        cmd.mul_sel = (kind_r == rau_pkg::KIND_MUL) ? 2'd3 : 2'd0;
        state_nxt   = S_MUL1;
      end
      S_MUL1: begin
        cmd.mul     = 1'b1;
        cmd.mul_sel = 2'd1;
        state_nxt   = S_MUL2;
      end
      S_MUL2: begin
        cmd.mul     = 1'b1;
        cmd.mul_sel = 2'd2;
        state_nxt   = S_COMB;
      end
      S_COMB: begin
        cmd.combine = 1'b1;
        state_nxt   = S_GCD;
      end
      S_GCD: begin
        if (stat.bad_den || stat.num_zero) begin
          state_nxt = S_OUT;
        end else if (stat.y_zero) begin
          cmd.div_start = 1'b1;
          cmd.div_mode  = rau_pkg::DM_NUM;
          state_nxt     = S_RNUM;
        end else begin
          cmd.div_start = 1'b1;
          cmd.div_mode  = rau_pkg::DM_GCD;
          state_nxt     = S_GWAIT;
        end
      end
      S_GWAIT: begin
        if (stat.div_done) begin
          cmd.gcd_step = 1'b1;
          state_nxt    = S_GCD;
        end
      end
      S_RNUM: begin
        if (stat.div_done) begin
          cmd.red_num   = 1'b1;
          cmd.div_start = 1'b1;
          cmd.div_mode  = rau_pkg::DM_DEN;
          state_nxt     = S_RDEN;
        end
      end
      S_RDEN: begin
        if (stat.div_done) begin
          cmd.red_den = 1'b1;
          waiting_nxt = 1'b1;
          state_nxt   = S_OUT;
        end
      end
      S_OUT: begin
        // hold until the previous beat has left the output register
        if (!out_valid_r || !out_stall) begin
          cmd.finish    = 1'b1;
          out_valid_nxt = 1'b1;
          waiting_nxt   = 1'b0;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      waiting_r   <= 1'b0;
      kind_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      waiting_r   <= waiting_nxt;
      kind_r      <= kind_nxt;
    end
  end

  assign out_valid = out_valid_r;

  a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !in_stall |-> state_r == S_IDLE) else $error("input taken while busy");
  a_finish_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> (!out_valid_r || !out_stall)) else $error("output overwritten");
  a_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r)) else $error("state not one-hot");
  a_wait_out: assert property (@(posedge clk) disable iff (!rst_n)
    waiting_r |-> state_r == S_OUT) else $error("reduced result lost");
endmodule
`default_nettype wire

>>> rtl/core/rational_arith_unit.sv
`default_nettype none
// channel | ports                         | beat
// input   | in_valid in_stall in_beat     | rau_pkg::in_beat_t
// result  | out_valid out_stall out_beat  | rau_pkg::out_beat_t
// A single 64-bit restoring divider (one quotient bit per cycle) serves gcd and reduction.
// One beat is worked at a time; the next is taken once the result is in the output register.
// Synchronous active-low reset clears the controller and output valid.
// A stalled result holds; a finished beat waits in S_OUT while the old one is stalled.
module rational_arith_unit #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire rau_pkg::in_beat_t  in_beat,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output rau_pkg::out_beat_t      out_beat
);
  rau_pkg::dp_cmd_t  cmd;
  rau_pkg::dp_stat_t stat;

  rau_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .kind(in_beat.kind),
    .stat(stat), .cmd(cmd)
  );

  rau_datapath #(.VALUE_WIDTH(VALUE_WIDTH)) u_dp (
    .clk(clk), .rst_n(rst_n), .in_beat(in_beat), .cmd(cmd), .stat(stat),
    .out_beat(out_beat)
  );
endmodule
`default_nettype wire
